// ----- hw/rtl/lms_pkg.sv -----
package lms_pkg;

  localparam int PIXEL_W    = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int MARGIN_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN       = 2'd2;

  localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 13'd480;
  localparam logic [MARGIN_W-1:0] RST_MARGIN       = 8'd10;

  localparam int MIN_SIZE = 3;

  typedef struct packed {
    logic emit;
    logic last;
  } lms_flags_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } lms_qstat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } lms_bstat_t;

endpackage

// ----- hw/rtl/local_max_3x3_suppress.sv -----
// a result's bottom-right pixel passes through the queue, the window stage and the output register
// throughput: one pixel per cycle while in_stall_o is low, set by the single write port of each line buffer
// a result waiting on out_stall_i does not block pixels that produce no result
// reset: counters clear at once; the line buffers are then swept to zero, entry by
// entry, during which in_stall_o is high and config writes are taken
module local_max_3x3_suppress import lms_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [PIXEL_W-1:0]    pixel_i,
  input  logic                  frame_start_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIXEL_W-1:0]    kept_value_o,
  output logic                  last_of_frame_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int DW = PIXEL_W + XW + $bits(lms_flags_t);

  logic [WIDTH_W-1:0]  frame_width_q;
  logic [HEIGHT_W-1:0] frame_height_q;
  logic [MARGIN_W-1:0] margin_q;

  logic               accept;
  logic [XW-1:0]      front_col;
  lms_flags_t         front_flags;
  logic [DW-1:0]      push_data, head;
  lms_qstat_t         qstat;
  lms_bstat_t         bstat;
  logic [PIXEL_W-1:0] head_pixel;
  logic [XW-1:0]      head_col;
  lms_flags_t         head_flags;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= RST_FRAME_WIDTH;
      frame_height_q <= RST_FRAME_HEIGHT;
      margin_q       <= RST_MARGIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[HEIGHT_W-1:0];
        CFG_MARGIN:       margin_q       <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = qstat.full || bstat.busy;
  assign accept     = in_valid_i && !in_stall_o;

  lms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_start_i  (frame_start_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .col_o          (front_col),
    .flags_o        (front_flags)
  );

  assign push_data = {pixel_i, front_col, front_flags};

  lms_queue #(
    .DW    (DW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (push_data),
    .pop_i       (bstat.pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  assign {head_pixel, head_col, head_flags} = head;

  lms_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (qstat.nonempty),
    .head_pixel_i    (head_pixel),
    .head_col_i      (head_col),
    .head_flags_i    (head_flags),
    .margin_i        (margin_q),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kept_value_o    (kept_value_o),
    .last_of_frame_o (last_of_frame_o),
    .stat_o          (bstat)
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.pop |-> qstat.nonempty)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qstat.full |-> !accept)
    else $error("queue pushed while full");

  a_no_pop_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.busy |-> !bstat.pop)
    else $error("item taken during line buffer sweep");

  a_sweep_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bstat.busy) |=> !bstat.busy)
    else $error("line buffer sweep restarted");

endmodule

// ----- hw/rtl/lms_front.sv -----
module lms_front import lms_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                frame_start_i,
  input  logic [WIDTH_W-1:0]  frame_width_i,
  input  logic [HEIGHT_W-1:0] frame_height_i,
  output logic [XW-1:0]       col_o,
  output lms_flags_t          flags_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [XW-1:0] col_q, col_d, c;
  logic [YW-1:0] row_q, row_d, r;
  logic [WW-1:0] w, c_inc;
  logic [HW-1:0] h, r_inc;

  always_comb begin
    if (32'(frame_width_i) < MIN_SIZE) begin
      w = WW'(MIN_SIZE);
    end else if (32'(frame_width_i) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_i);
    end
    if (32'(frame_height_i) < MIN_SIZE) begin
      h = HW'(MIN_SIZE);
    end else if (32'(frame_height_i) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_i);
    end
  end

  always_comb begin
    c     = frame_start_i ? '0 : col_q;
    r     = frame_start_i ? '0 : row_q;
    c_inc = WW'(c) + WW'(1);
    r_inc = HW'(r) + HW'(1);
    flags_o.emit = (r >= YW'(2)) && (c >= XW'(2));
    flags_o.last = (r_inc == h) && (c_inc == w);
    col_o = c;
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (c_inc >= w) begin
        col_d = '0;
        row_d = (r_inc >= h) ? '0 : r_inc[YW-1:0];
      end else begin
        col_d = c_inc[XW-1:0];
        row_d = r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ----- hw/rtl/lms_queue.sv -----
module lms_queue import lms_pkg::*; #(
  parameter int DW    = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] push_data_i,
  input  logic          pop_i,
  output logic [DW-1:0] head_o,
  output lms_qstat_t    stat_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] entry_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_data_i;
    end
  end

  assign head_o          = entry_q[rd_q];
  assign stat_o.full     = (cnt_q == CW'(DEPTH));
  assign stat_o.nonempty = (cnt_q != '0);

endmodule

// ----- hw/rtl/lms_back.sv -----
module lms_back import lms_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int XW = $clog2(MAX_WIDTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                head_valid_i,
  input  logic [PIXEL_W-1:0]  head_pixel_i,
  input  logic [XW-1:0]       head_col_i,
  input  lms_flags_t          head_flags_i,
  input  logic [MARGIN_W-1:0] margin_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [PIXEL_W-1:0]  kept_value_o,
  output logic                last_of_frame_o,
  output lms_bstat_t          stat_o
);

  logic [PIXEL_W-1:0] above_mem [MAX_WIDTH];
  logic [PIXEL_W-1:0] two_mem   [MAX_WIDTH];
  logic [PIXEL_W-1:0] above_rd_q, two_rd_q;

  logic               clr_busy_q;
  logic [XW-1:0]      clr_cnt_q;

  logic               a_v_q;
  logic [PIXEL_W-1:0] a_pixel_q;
  logic [XW-1:0]      a_col_q;
  lms_flags_t         a_flags_q;

  logic [PIXEL_W-1:0] win_q [6];

  logic               ov_q;
  logic [PIXEL_W-1:0] kept_q;
  logic               last_q;

  logic               adv, pop, we;
  logic [XW-1:0]      wa;
  logic [PIXEL_W-1:0] wd_above, wd_two, mx;
  logic               keep;

  function automatic logic [PIXEL_W-1:0] max2(input logic [PIXEL_W-1:0] a,
                                               input logic [PIXEL_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  always_comb begin
    adv = a_v_q && (!a_flags_q.emit || !ov_q || !out_stall_i);
    pop = head_valid_i && !clr_busy_q && (!a_v_q || adv);
    we  = clr_busy_q || adv;
    wa  = clr_busy_q ? clr_cnt_q : a_col_q;
    wd_above = clr_busy_q ? '0 : a_pixel_q;
    wd_two   = clr_busy_q ? '0 : above_rd_q;
    mx = max2(max2(max2(win_q[0], win_q[1]), max2(win_q[2], win_q[3])),
              max2(max2(win_q[5], two_rd_q), max2(above_rd_q, a_pixel_q)));
    keep = ({1'b0, win_q[4]} + {1'b0, margin_i}) > {1'b0, mx};
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      above_mem[wa] <= wd_above;
      two_mem[wa]   <= wd_two;
    end
    if (pop) begin
      above_rd_q <= (we && wa == head_col_i) ? wd_above : above_mem[head_col_i];
      two_rd_q   <= (we && wa == head_col_i) ? wd_two   : two_mem[head_col_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + XW'(1);
      if (clr_cnt_q == XW'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (pop) begin
        a_v_q <= 1'b1;
      end else if (adv) begin
        a_v_q <= 1'b0;
      end
      if (adv && a_flags_q.emit) begin
        ov_q <= 1'b1;
      end else if (!out_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      a_pixel_q <= head_pixel_i;
      a_col_q   <= head_col_i;
      a_flags_q <= head_flags_i;
    end
    if (adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= two_rd_q;
      win_q[4] <= above_rd_q;
      win_q[5] <= a_pixel_q;
    end
    if (adv && a_flags_q.emit) begin
      kept_q <= keep ? win_q[4] : '0;
      last_q <= a_flags_q.last;
    end
  end

  assign out_valid_o     = ov_q;
  assign kept_value_o    = kept_q;
  assign last_of_frame_o = last_q;
  assign stat_o.pop      = pop;
  assign stat_o.busy     = clr_busy_q;

endmodule

// ----- bench/tb_local_max_3x3_suppress.sv -----
module tb_local_max_3x3_suppress;
  timeunit 1ns;
  timeprecision 1ps;
  import lms_pkg::*;

  localparam int CLOCK_HALF    = 6;
  localparam int RESET_CYCLES  = 6;
  localparam int RANDOM_ITEMS  = 300;
  localparam int WIDE_ITEMS    = 40;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_MAX    = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef logic [PIXEL_W-1:0] pix_t;

  typedef struct packed {
    pix_t value;
    logic first;
  } pix_word_t;

  typedef struct packed {
    pix_t kept;
    logic last;
  } nms_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  pix_t                  pixel_i = '0;
  logic                  frame_start_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  pix_t                  kept_value_o;
  logic                  last_of_frame_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  local_max_3x3_suppress dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .frame_start_i  (frame_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kept_value_o   (kept_value_o),
    .last_of_frame_o(last_of_frame_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always begin
    #CLOCK_HALF clk_i = 1'b1;
    #CLOCK_HALF clk_i = 1'b0;
  end

  // register copies and window state of the predictor
  logic [WIDTH_W-1:0]  width_reg  = RST_FRAME_WIDTH;
  logic [HEIGHT_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic [MARGIN_W-1:0] margin_reg = RST_MARGIN;
  pix_t row_prev  [DEF_MAX_WIDTH] = '{default: '0};
  pix_t row_prev2 [DEF_MAX_WIDTH] = '{default: '0};
  pix_t win       [6] = '{default: '0};
  int   col_pos = 0;
  int   row_pos = 0;

  pix_word_t   pixel_q [$];
  nms_result_t expected_q [$];

  int  words_queued = 0;
  int  words_taken = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  tx_gap = 0;
  int  rx_run = 0;
  int  hold_left = 0;
  int  hold_asked = 0;
  int  hold_given = 0;
  int  quiet_cycles = 0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;

  function automatic int size_clamp(int v, int hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int draw_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pix_t rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return pix_t'($urandom);
    if (r < 8) return pix_t'($urandom_range(180, 210));
    if (r == 8) return '0;
    return '1;
  endfunction

  function automatic int pick_width();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(3, 10);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 80) return $urandom_range(11, 40);
    if (r < 90) return ($urandom_range(1, 3) << WIDTH_W) | MIN_SIZE;
    return MIN_SIZE;
  endfunction

  function automatic int pick_height();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return $urandom_range(3, 6);
    if (r < 80) return $urandom_range(0, 2);
    return MIN_SIZE;
  endfunction

  function automatic int pick_margin();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 0;
    if (r < 50) return 255;
    return ($urandom_range(0, 31) << MARGIN_W) | $urandom_range(0, 255);
  endfunction

  // one pixel through the suppression window
  task automatic suppress_step(input pix_t px, input logic fs);
    int          w, h, c, r, mx;
    pix_t        top, mid;
    pix_t        nb [8];
    nms_result_t res;
    w = size_clamp(int'(width_reg), DEF_MAX_WIDTH);
    h = size_clamp(int'(height_reg), DEF_MAX_HEIGHT);
    if (fs) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    top = row_prev2[c];
    mid = row_prev[c];
    if (r >= 2 && c >= 2) begin
      nb = '{win[0], win[1], win[2], win[3], win[5], top, mid, px};
      mx = 0;
      foreach (nb[k]) if (int'(nb[k]) > mx) mx = nb[k];
      res.kept = (int'(win[4]) > mx - int'(margin_reg)) ? win[4] : '0;
      res.last = (r == h - 1 && c == w - 1);
      expected_q.push_back(res);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top;
    win[4] = mid;
    win[5] = px;
    row_prev2[c] = mid;
    row_prev[c] = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // pixel driver
  always @(posedge clk_i) begin
    pix_word_t wd;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        suppress_step(pixel_i, frame_start_i);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          wd = pixel_q.pop_front();
          in_valid_i <= 1'b1;
          pixel_i <= wd.value;
          frame_start_i <= wd.first;
          tx_gap = draw_gap(tx_calm);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk_i) begin
    nms_result_t want, got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.kept = kept_value_o;
        got.last = last_of_frame_o;
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("result %0d unexpected: kept %0d last %0b",
                     results_seen, got.kept, got.last);
        end else begin
          want = expected_q.pop_front();
          if (got.kept !== want.kept || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("result %0d: expected kept %0d last %0b, got kept %0d last %0b",
                       results_seen, want.kept, want.last, got.kept, got.last);
          end
        end
        results_seen++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_given < hold_asked) begin
        hold_given++;
        hold_left = HOLD_CYCLES - 1;
        out_stall_i <= 1'b1;
      end else if (rx_run > 0) begin
        rx_run--;
        out_stall_i <= 1'b1;
      end else begin
        rx_run = draw_gap(rx_calm);
        if (rx_run > 0) begin
          rx_run--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("local_max_3x3_suppress: mismatch");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
    logic [CFG_DATA_W-1:0] bits;
    bits = CFG_DATA_W'(data);
    cfg_index_i <= idx;
    cfg_data_i <= bits;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FRAME_WIDTH:  width_reg = bits[WIDTH_W-1:0];
      CFG_FRAME_HEIGHT: height_reg = bits[HEIGHT_W-1:0];
      CFG_MARGIN:       margin_reg = bits[MARGIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int wd, input int ht, input int mg,
                           input bit do_w, input bit do_h, input bit do_m, input bit spare);
    if (do_w) write_reg(CFG_FRAME_WIDTH, wd);
    if (do_h) write_reg(CFG_FRAME_HEIGHT, ht);
    if (do_m) write_reg(CFG_MARGIN, mg);
    if (spare) write_reg(CFG_SPARE, $urandom_range(0, (1 << CFG_DATA_W) - 1));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic queue_pixel(input pix_t v, input logic fs);
    pix_word_t wd;
    wd.value = v;
    wd.first = fs;
    pixel_q.push_back(wd);
    words_queued++;
  endtask

  task automatic queue_run(input int count, input bit fs_first, input int fs_odds);
    for (int i = 0; i < count; i++)
      queue_pixel(rand_pixel(),
                  (i == 0 && fs_first) || (fs_odds > 0 && $urandom_range(1, fs_odds) == 1));
  endtask

  // hold the stream until every word is taken and every result is back
  task automatic drain();
    while (words_taken != words_queued) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int w, h, nf, mode, phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sizes below range saturate to 3x3, zero margin, single bright peak
    configure(0, 1, 0, 1'b1, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? pix_t'('1) : pix_t'('0), i == 0);
    drain();
    // wrap with no frame start, dark centre under full margin
    configure(0, 0, 255, 1'b0, 1'b0, 1'b1, 1'b0);
    for (int i = 0; i < 9; i++) queue_pixel((i == 4) ? pix_t'('0) : pix_t'('1), 1'b0);
    drain();

    phase = 0;
    while (words_queued < RANDOM_ITEMS) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);
      if (phase == 0 || phase == 6) begin
        configure($urandom_range(3, 6), $urandom_range(3, 6), pick_margin(),
                  1'b1, 1'b1, 1'b1, 1'b0);
        tx_calm = 1'b1;
        rx_calm = 1'b0;
        hold_asked++;
        mode = 0;
        nf = 4;
      end else begin
        configure(pick_width(), pick_height(), pick_margin(), $urandom_range(0, 1),
                  $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 9) == 0);
        mode = $urandom_range(0, 9);
        nf = $urandom_range(1, 3);
      end
      w = size_clamp(int'(width_reg), DEF_MAX_WIDTH);
      h = size_clamp(int'(height_reg), DEF_MAX_HEIGHT);
      if (mode < 6) begin
        repeat (nf) queue_run(w * h, 1'b1, 0);
      end else if (mode == 6) begin
        queue_run(w * h, 1'b0, 0);
      end else if (mode == 7) begin
        queue_run($urandom_range(1, w * h - 1), 1'b1, 0);
        queue_run(w * h, 1'b1, 0);
      end else begin
        queue_run($urandom_range(10, 40), $urandom_range(0, 1), 8);
      end
      drain();
      phase++;
    end

    // tallest frame, saturated from above, never completed
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    configure($urandom_range(3, 8), (1 << HEIGHT_W) - 1, pick_margin(),
              1'b1, 1'b1, 1'b1, 1'b0);
    queue_run(80, 1'b1, 0);
    queue_run(20, 1'b0, 8);
    drain();

    // widest frame, saturated from above, start of the first row only
    configure((1 << WIDTH_W) - 1, MIN_SIZE, pick_margin(), 1'b1, 1'b1, 1'b1, 1'b0);
    queue_run(WIDE_ITEMS, 1'b1, 0);
    drain();

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("local_max_3x3_suppress: match");
    end else begin
      $display("local_max_3x3_suppress: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/lms_pkg.sv
hw/rtl/lms_front.sv
hw/rtl/lms_queue.sv
hw/rtl/lms_back.sv
hw/rtl/local_max_3x3_suppress.sv
bench/tb_local_max_3x3_suppress.sv
